// ===== hdl/eatl_pkg.sv =====
// ----------------------------------------------------------------------------
// eatl_pkg
// Shared widths, constants and types of the echo averaging tank level block.
// ----------------------------------------------------------------------------
package eatl_pkg;

  localparam int unsigned CFG_W        = 14;
  localparam int unsigned COUNT_CFG_W  = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned ECHO_W       = 16;
  localparam int unsigned DIST_W       = 15;
  localparam int unsigned AVG_W        = 15;
  localparam int unsigned LEVEL_W      = 11;
  localparam int unsigned GOOD_W       = 5;

  localparam int unsigned MAX_SAMPLES_DEF = 16;
  localparam int unsigned CNT_W_DEF       = $clog2(MAX_SAMPLES_DEF + 1);
  localparam int unsigned SUM_W_DEF       = CFG_W + CNT_W_DEF;

  // distance in cm q4 = (echo_us * 557) >> 11
  localparam int unsigned DIST_SCALE_W = 10;
  localparam logic [DIST_SCALE_W-1:0] DIST_SCALE = 10'd557;
  localparam int unsigned DIST_SHIFT   = 11;
  localparam int unsigned PROD_W       = ECHO_W + DIST_SCALE_W;

  // percent q4 full scale
  localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 11'd1600;
  localparam int unsigned LVL_NUM_W = CFG_W + LEVEL_W;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0]       MIN_DIST_RST      = 14'd32;
  localparam logic [CFG_W-1:0]       MAX_DIST_RST      = 14'd6400;
  localparam logic [CFG_W-1:0]       TANK_HEIGHT_RST   = 14'd1600;
  localparam logic [CFG_W-1:0]       SENSOR_OFFSET_RST = 14'd0;
  localparam logic [COUNT_CFG_W-1:0] BATCH_SIZE_RST    = 5'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST      = 3'd0,
    CFG_MAX_DIST      = 3'd1,
    CFG_TANK_HEIGHT   = 3'd2,
    CFG_SENSOR_OFFSET = 3'd3,
    CFG_BATCH_SIZE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]       min_dist;
    logic [CFG_W-1:0]       max_dist;
    logic [CFG_W-1:0]       tank_height;
    logic [CFG_W-1:0]       sensor_offset;
    logic [COUNT_CFG_W-1:0] batch_size;
  } cfg_t;

endpackage

// ===== hdl/eatl_if.sv =====
// ----------------------------------------------------------------------------
// eatl_if
// Valid/ready channels for echo samples and level results.
// ----------------------------------------------------------------------------
interface eatl_echo_if;
  import eatl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output echo_us, input ready);
  modport sink   (input valid, input echo_us, output ready);
endinterface

interface eatl_result_if;
  import eatl_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_valid;
  logic [AVG_W-1:0]   avg_distance_q4;
  logic [LEVEL_W-1:0] level_percent_q4;
  logic [GOOD_W-1:0]  good_samples;

  modport source (output valid, output result_valid, output avg_distance_q4,
                  output level_percent_q4, output good_samples, input ready);
  modport sink   (input valid, input result_valid, input avg_distance_q4,
                  input level_percent_q4, input good_samples, output ready);
endinterface

// ===== hdl/eatl_front.sv =====
// ----------------------------------------------------------------------------
// eatl_front
// Converts echo widths to distances, qualifies them and accumulates a batch.
// ----------------------------------------------------------------------------
module eatl_front #(
  parameter int unsigned MAX_SAMPLES = eatl_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned CNT_W       = eatl_pkg::CNT_W_DEF,
  parameter int unsigned SUM_W       = eatl_pkg::SUM_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  eatl_pkg::cfg_t         cfg_i,
  eatl_echo_if.sink              echo_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [SUM_W+CNT_W-1:0] push_data_o
);
  import eatl_pkg::*;

  logic              s1_valid_q;
  logic              s1_nz_q;
  logic [DIST_W-1:0] s1_dist_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  tally_q;
  logic [SUM_W-1:0]  sum_q;

  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  batch_len;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  tally_inc;
  logic [SUM_W-1:0]  sum_inc;
  logic              hit;
  logic              close;
  logic              s1_adv;

  always_comb begin
    if (cfg_i.batch_size == '0) begin
      batch_len = CNT_W'(1);
    end else if (32'(cfg_i.batch_size) > MAX_SAMPLES) begin
      batch_len = CNT_W'(MAX_SAMPLES);
    end else begin
      batch_len = CNT_W'(cfg_i.batch_size);
    end
  end

  assign prod      = PROD_W'(echo_i.echo_us) * PROD_W'(DIST_SCALE);
  assign idx_inc   = idx_q + CNT_W'(1);
  assign close     = (idx_inc >= batch_len);
  assign hit       = s1_nz_q && ({1'b0, cfg_i.min_dist} <= s1_dist_q)
                     && (s1_dist_q <= {1'b0, cfg_i.max_dist});
  assign sum_inc   = sum_q + (hit ? SUM_W'(s1_dist_q) : '0);
  assign tally_inc = tally_q + CNT_W'(hit);
  assign s1_adv    = !close || push_ready_i;

  assign echo_i.ready = !s1_valid_q || s1_adv;
  assign push_valid_o = s1_valid_q && close;
  assign push_data_o  = {sum_inc, tally_inc};

  // distance stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (echo_i.ready) begin
      s1_valid_q <= echo_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (echo_i.valid && echo_i.ready) begin
      s1_dist_q <= prod[DIST_SHIFT +: DIST_W];
      s1_nz_q   <= (echo_i.echo_us != '0);
    end
  end

  // batch accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      tally_q <= '0;
      sum_q   <= '0;
    end else if (s1_valid_q && s1_adv) begin
      if (close) begin
        idx_q   <= '0;
        tally_q <= '0;
        sum_q   <= '0;
      end else begin
        idx_q   <= idx_inc;
        tally_q <= tally_inc;
        sum_q   <= sum_inc;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < CNT_W'(MAX_SAMPLES))
    else $error("batch index out of range");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= idx_q)
    else $error("valid tally exceeds inputs taken");

endmodule

// ===== hdl/eatl_queue.sv =====
// ----------------------------------------------------------------------------
// eatl_queue
// Short queue of closed batches between accumulator and result engine.
// ----------------------------------------------------------------------------
module eatl_queue #(
  parameter int unsigned DATA_W = eatl_pkg::SUM_W_DEF + eatl_pkg::CNT_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import eatl_pkg::*;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [COUNT_W-1:0] count_q;
  logic               do_push;
  logic               do_pop;

  assign push_ready_o = (count_q != COUNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - COUNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/eatl_divider.sv =====
// ----------------------------------------------------------------------------
// eatl_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eatl_divider #(
  parameter int unsigned N_W = eatl_pkg::LVL_NUM_W,
  parameter int unsigned D_W = eatl_pkg::CFG_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [D_W-1:0]   rem_q;
  logic [N_W-1:0]   quo_q;
  logic [D_W-1:0]   div_q;

  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             ge;

  assign shifted    = {rem_q, quo_q[N_W-1]};
  assign trial      = shifted - {1'b0, div_q};
  assign ge         = (shifted >= {1'b0, div_q});
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(N_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
      quo_q <= {quo_q[N_W-2:0], ge};
    end
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== hdl/eatl_back.sv =====
// ----------------------------------------------------------------------------
// eatl_back
// Averages a closed batch, derives the level and holds the result register.
// ----------------------------------------------------------------------------
module eatl_back #(
  parameter int unsigned CNT_W = eatl_pkg::CNT_W_DEF,
  parameter int unsigned SUM_W = eatl_pkg::SUM_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  eatl_pkg::cfg_t         cfg_i,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  logic [SUM_W+CNT_W-1:0] pop_data_i,
  eatl_result_if.source          result_o
);
  import eatl_pkg::*;

  localparam int unsigned DIV_N_W = (SUM_W > LVL_NUM_W) ? SUM_W : LVL_NUM_W;
  localparam int unsigned H_W     = CFG_W + 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CLAMP,
    ST_SCALE,
    ST_LVL,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   tally_q;
  logic [AVG_W-1:0]   avg_q;
  logic [CFG_W-1:0]   h_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic               ok_q;

  logic               res_valid_q;
  logic               res_ok_q;
  logic [AVG_W-1:0]   res_avg_q;
  logic [LEVEL_W-1:0] res_lvl_q;
  logic [GOOD_W-1:0]  res_good_q;

  logic [SUM_W-1:0]     pop_sum;
  logic [CNT_W-1:0]     pop_tally;
  logic                 div_start;
  logic [DIV_N_W-1:0]   div_dividend;
  logic [CFG_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIV_N_W-1:0]   div_quotient;
  logic [LVL_NUM_W-1:0] lvl_num;
  logic signed [H_W-1:0] h_raw;
  logic [CFG_W-1:0]     h_clamped;

  assign pop_sum     = pop_data_i[SUM_W+CNT_W-1:CNT_W];
  assign pop_tally   = pop_data_i[CNT_W-1:0];
  assign pop_ready_o = (state_q == ST_IDLE);

  assign lvl_num = LVL_NUM_W'(h_q) * LVL_NUM_W'(LEVEL_SCALE);
  assign h_raw   = $signed({3'b000, cfg_i.tank_height}) - $signed({2'b00, avg_q})
                   - $signed({3'b000, cfg_i.sensor_offset});

  always_comb begin
    if (h_raw < 0) begin
      h_clamped = '0;
    end else if (h_raw > $signed({3'b000, cfg_i.tank_height})) begin
      h_clamped = cfg_i.tank_height;
    end else begin
      h_clamped = h_raw[CFG_W-1:0];
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_N_W'(pop_sum);
    div_divisor  = CFG_W'(pop_tally);
    if (state_q == ST_IDLE) begin
      div_start = pop_valid_i && (pop_tally != '0);
    end else if (state_q == ST_SCALE) begin
      div_start    = 1'b1;
      div_dividend = DIV_N_W'(lvl_num);
      div_divisor  = cfg_i.tank_height;
    end
  end

  eatl_divider #(
    .N_W (DIV_N_W),
    .D_W (CFG_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tally_q     <= '0;
      avg_q       <= '0;
      h_q         <= '0;
      lvl_q       <= '0;
      ok_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_ok_q    <= 1'b0;
      res_avg_q   <= '0;
      res_lvl_q   <= '0;
      res_good_q  <= '0;
    end else begin
      if (result_o.ready && state_q != ST_EMIT) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            tally_q <= pop_tally;
            if (pop_tally == '0) begin
              ok_q    <= 1'b0;
              avg_q   <= '0;
              lvl_q   <= '0;
              state_q <= ST_EMIT;
            end else begin
              ok_q    <= 1'b1;
              state_q <= ST_AVG;
            end
          end
        end
        ST_AVG: begin
          if (div_done) begin
            avg_q   <= div_quotient[AVG_W-1:0];
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (cfg_i.tank_height == '0) begin
            lvl_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            h_q     <= h_clamped;
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_q <= ST_LVL;
        end
        ST_LVL: begin
          if (div_done) begin
            lvl_q   <= div_quotient[LEVEL_W-1:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res_valid_q || result_o.ready) begin
            res_valid_q <= 1'b1;
            res_ok_q    <= ok_q;
            res_avg_q   <= avg_q;
            res_lvl_q   <= lvl_q;
            res_good_q  <= GOOD_W'(tally_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid            = res_valid_q;
  assign result_o.result_valid     = res_ok_q;
  assign result_o.avg_distance_q4  = res_avg_q;
  assign result_o.level_percent_q4 = res_lvl_q;
  assign result_o.good_samples     = res_good_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_AVG || state_q == ST_LVL))
    else $error("divider result outside a wait state");

endmodule

// ===== hdl/echo_averaging_tank_level.sv =====
// ----------------------------------------------------------------------------
// echo_averaging_tank_level
// Ultrasonic echo distance averaging with tank level in percent.
// ----------------------------------------------------------------------------
// echo_i carries one echo width in microseconds per transaction, zero meaning
// timeout. Each width becomes a distance in cm q4; distances within the
// configured limits are summed and counted. Once a batch of the configured
// size is complete one transaction leaves on result_o with the average
// distance, the level in percent q4 and the number of good samples.
// The front takes one echo per cycle unless echo_i stalls: a distance stage and
// an accumulator. A closed batch enters a two-entry queue. The result engine
// runs two serial divisions on one shared restoring divider and takes a new
// closed batch only once it has emitted the previous result; it skips both
// divisions when no sample was good. echo_i stalls only when the queue is full
// and a batch closes.
// The cfg port writes one register per cycle when cfg_we_i is high; the user
// must use it only while the block is idle, which the block does not enforce.
// Reset restores the register defaults and empties the accumulator, queue
// and result register. A stalled result_o holds its result while the engine
// prepares the next one.
// ----------------------------------------------------------------------------
module echo_averaging_tank_level #(
  parameter int unsigned MAX_SAMPLES = eatl_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  eatl_echo_if.sink                       echo_i,
  eatl_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [eatl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eatl_pkg::CFG_W-1:0]      cfg_data_i
);
  import eatl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = CFG_W + CNT_W;

  cfg_t                   cfg_q;
  logic                   push_valid;
  logic                   push_ready;
  logic [SUM_W+CNT_W-1:0] push_data;
  logic                   pop_valid;
  logic                   pop_ready;
  logic [SUM_W+CNT_W-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist      <= MIN_DIST_RST;
      cfg_q.max_dist      <= MAX_DIST_RST;
      cfg_q.tank_height   <= TANK_HEIGHT_RST;
      cfg_q.sensor_offset <= SENSOR_OFFSET_RST;
      cfg_q.batch_size    <= BATCH_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DIST:      cfg_q.min_dist      <= cfg_data_i;
        CFG_MAX_DIST:      cfg_q.max_dist      <= cfg_data_i;
        CFG_TANK_HEIGHT:   cfg_q.tank_height   <= cfg_data_i;
        CFG_SENSOR_OFFSET: cfg_q.sensor_offset <= cfg_data_i;
        CFG_BATCH_SIZE:    cfg_q.batch_size    <= cfg_data_i[COUNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  eatl_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .echo_i       (echo_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  eatl_queue #(
    .DATA_W (SUM_W + CNT_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  eatl_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule
